// File: hw/rtl/wiub_pkg.sv
// Package for the weighted interval union binner: widths, codes and shared types.
// No dependencies.
package wiub_pkg;
    localparam int SOURCES    = 16;
    localparam int IDX_BITS   = 4;
    localparam int VAL_BITS   = 32;
    localparam int SUM_BITS   = 36;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_BIN   = 2'd2;

    typedef struct packed {
        logic [VAL_BITS-1:0] weight;
        logic [VAL_BITS-1:0] advance;
        logic [VAL_BITS-1:0] length;
    } t_div_req;
endpackage

// File: hw/rtl/wiub_muldiv.sv
// Contribution unit: floor(weight*advance/length), capped at weight, zero for zero length.
// Depends on wiub_pkg. Restoring division, one quotient bit per cycle.
module wiub_muldiv import wiub_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_div_req            i_req,
    output logic                o_done,
    output logic [VAL_BITS-1:0] o_result
);
    logic [63:0]         r_num;
    logic [VAL_BITS:0]   r_rem;
    logic [VAL_BITS-1:0] r_den;
    logic [VAL_BITS-1:0] r_quo;
    logic [5:0]          r_cnt;
    logic                r_busy;
    logic                r_mul;
    logic [VAL_BITS:0]   n_rem;
    logic [VAL_BITS:0]   w_trial;

    assign n_rem   = {r_rem[VAL_BITS-1:0], r_num[63]};
    assign w_trial = n_rem - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_den <= i_req.length;
                if (i_req.length == '0) begin
                    o_result <= '0;
                    o_done   <= 1'b1;
                end else if (i_req.advance >= i_req.length) begin
                    o_result <= i_req.weight;
                    o_done   <= 1'b1;
                end else begin
                    r_num <= {32'd0, i_req.weight};
                    r_quo <= i_req.advance;
                    r_mul <= 1'b1;
                    r_busy <= 1'b1;
                end
            end else if (r_mul) begin
                r_num <= 64'(r_num[31:0]) * 64'(r_quo);
                r_rem <= '0;
                r_cnt <= 6'd0;
                r_mul <= 1'b0;
            end else if (r_busy) begin
                r_num <= {r_num[62:0], 1'b0};
                if (!w_trial[VAL_BITS]) begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[VAL_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[VAL_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_result <= !w_trial[VAL_BITS] ? {r_quo[VAL_BITS-2:0], 1'b1}
                                                   : {r_quo[VAL_BITS-2:0], 1'b0};
                end
            end
        end
    end
endmodule

// File: hw/rtl/weighted_interval_union_binner_unit.sv
// Top level of the weighted interval union binner: control sequencer and source store.
// Depends on wiub_pkg and wiub_muldiv.
// One beat per event. A flagged event that is dropped presents its result in the cycle after
// acceptance; an event that opens a set or does not advance passes through ST_UPD and ST_OUT.
// An advancing event walks all 16 source entries of the store, passing over inactive sources;
// each active source goes through read, set-up and the shared multiply-divide, which skips
// the division when its length is zero or the advance reaches it. The result is held in an
// output register; the next beat is taken once that result has been accepted.
module weighted_interval_union_binner_unit import wiub_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: bound_value[31:0], source_index[35:32], is_start[36], far_end[68:37],
    //        source_weight[100:69], zero fill [103:101]
    input  logic [103:0] s_axis_tdata,
    // tuser: first_of_set
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: bin_edge[31:0], bin_total[67:32], bad_event[68], zero fill [71:69]
    output logic [71:0]  m_axis_tdata,
    // tuser: emit_kind
    output logic [1:0]   m_axis_tuser
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_CALC  = 6'b001000,
        ST_UPD   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    logic [SOURCES-1:0]       r_active;
    logic [VAL_BITS-1:0]      r_prev;
    logic                     r_open;
    logic [2*VAL_BITS-1:0]    r_mem [SOURCES];
    logic [2*VAL_BITS-1:0]    r_rd;
    logic [IDX_BITS:0]        r_scan;
    logic [SUM_BITS-1:0]      r_sum;
    logic [VAL_BITS-1:0]      r_val;
    logic [IDX_BITS-1:0]      r_idx;
    logic                     r_start_ev;
    logic [VAL_BITS-1:0]      r_far;
    logic [VAL_BITS-1:0]      r_wgt;
    logic [1:0]               r_kind;
    logic                     r_obusy;
    logic                     r_div_go;
    t_div_req                 r_req;
    logic                     w_done;
    logic [VAL_BITS-1:0]      w_contrib;
    logic [SUM_BITS:0]        w_add;

    wiub_muldiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_req   (r_req),
        .o_done  (w_done),
        .o_result(w_contrib)
    );

    assign s_axis_tready = (r_state == ST_IDLE) && !r_obusy;
    assign m_axis_tvalid = r_obusy;
    assign w_add = {1'b0, r_sum} + {{(SUM_BITS-VAL_BITS+1){1'b0}}, w_contrib};

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd <= r_mem[r_scan[IDX_BITS-1:0]];
        end
        if (r_state == ST_UPD && r_start_ev) begin
            r_mem[r_idx] <= {r_wgt, (r_far >= r_val) ? r_far - r_val : {VAL_BITS{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= '0;
            r_prev   <= '0;
            r_open   <= 1'b0;
            r_obusy  <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                r_obusy <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_val      <= s_axis_tdata[31:0];
                        r_idx      <= s_axis_tdata[35:32];
                        r_start_ev <= s_axis_tdata[36];
                        r_far      <= s_axis_tdata[68:37];
                        r_wgt      <= s_axis_tdata[100:69];
                        r_sum      <= '0;
                        r_scan     <= '0;
                        if (s_axis_tuser) begin
                            r_active <= '0;
                            r_open   <= 1'b1;
                            r_prev   <= s_axis_tdata[31:0];
                            r_kind   <= KIND_START;
                            r_state  <= ST_UPD;
                        end else if (!r_open || s_axis_tdata[31:0] < r_prev) begin
                            m_axis_tdata <= {3'd0, 1'b1, 36'd0, 32'd0};
                            m_axis_tuser <= KIND_NONE;
                            r_obusy      <= 1'b1;
                        end else if (s_axis_tdata[31:0] != r_prev) begin
                            r_kind  <= KIND_BIN;
                            r_state <= ST_READ;
                        end else begin
                            r_kind  <= KIND_NONE;
                            r_state <= ST_UPD;
                        end
                    end
                end
                ST_READ: begin
                    if (r_scan[IDX_BITS]) begin
                        r_prev  <= r_val;
                        r_state <= ST_UPD;
                    end else if (r_active[r_scan[IDX_BITS-1:0]]) begin
                        r_state <= ST_WAIT;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                ST_WAIT: begin
                    r_req.weight  <= r_rd[2*VAL_BITS-1:VAL_BITS];
                    r_req.length  <= r_rd[VAL_BITS-1:0];
                    r_req.advance <= r_val - r_prev;
                    r_div_go      <= 1'b1;
                    r_state       <= ST_CALC;
                end
                ST_CALC: begin
                    if (w_done) begin
                        r_sum  <= w_add[SUM_BITS] ? {SUM_BITS{1'b1}} : w_add[SUM_BITS-1:0];
                        r_scan <= r_scan + 1'b1;
                        r_state <= ST_READ;
                    end
                end
                ST_UPD: begin
                    if (r_start_ev) begin
                        r_active[r_idx] <= 1'b1;
                    end else if (r_active[r_idx]) begin
                        r_active[r_idx] <= 1'b0;
                    end
                    m_axis_tdata <= {3'd0, !r_start_ev && !r_active[r_idx],
                                     (r_kind == KIND_BIN) ? r_sum : {SUM_BITS{1'b0}},
                                     (r_kind == KIND_NONE) ? {VAL_BITS{1'b0}} : r_val};
                    m_axis_tuser <= r_kind;
                    r_state      <= ST_OUT;
                end
                ST_OUT: begin
                    r_obusy <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> !s_axis_tready)
        else $error("input taken during divide");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !m_axis_tvalid)
        else $error("input taken with result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> m_axis_tvalid)
        else $error("result not presented");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_NONE && m_axis_tdata[31:0] != '0)
        |-> 1'b0)
        else $error("edge on empty result");
endmodule

// File: tb/weighted_interval_union_binner_unit_tb.sv
// Testbench for weighted_interval_union_binner_unit: drives event beats, predicts each
// result beat in a scoreboard class and compares it field by field.
// Depends on wiub_pkg and the RTL of the block.
module weighted_interval_union_binner_unit_tb import wiub_pkg::*; ();

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] edge_v;
        logic [35:0] weight;
        logic        bad;
    } t_bin_res;

    class binner_board;
        bit          active_q[SOURCES];
        logic [31:0] len_q[SOURCES];
        logic [31:0] wgt_q[SOURCES];
        logic [31:0] prev_q;
        bit          open_q;
        t_bin_res    pending_q[$];
        int          errors;

        function void note_event(bit first, logic [31:0] val, logic [3:0] idx, bit start,
                                 logic [31:0] far_v, logic [31:0] w);
            t_bin_res r;
            logic [63:0] sum, part, adv;
            r.kind = KIND_NONE; r.edge_v = 0; r.weight = 0; r.bad = 0;
            sum = 0;
            if (first) begin
                foreach (active_q[s]) active_q[s] = 0;
                open_q = 1; prev_q = val; r.kind = KIND_START; r.edge_v = val;
            end else if (!open_q || val < prev_q) begin
                r.bad = 1;
                pending_q = {pending_q, r};
                return;
            end else if (val != prev_q) begin
                adv = val - prev_q;
                for (int s = 0; s < SOURCES; s++) begin
                    if (active_q[s]) begin
                        if (len_q[s] == 0) part = 0;
                        else if (adv >= len_q[s]) part = wgt_q[s];
                        else part = (64'(wgt_q[s]) * adv) / len_q[s];
                        sum += part;
                        if (sum > 64'hF_FFFF_FFFF) sum = 64'hF_FFFF_FFFF;
                    end
                end
                r.kind = KIND_BIN; r.edge_v = val; r.weight = sum[35:0]; prev_q = val;
            end
            if (start) begin
                len_q[idx] = (far_v >= val) ? far_v - val : 0;
                wgt_q[idx] = w; active_q[idx] = 1;
            end else if (active_q[idx]) active_q[idx] = 0;
            else r.bad = 1;
            pending_q = {pending_q, r};
        endfunction

        task check_bin(logic [71:0] d, logic [1:0] u);
            t_bin_res e;
            if (pending_q.size() == 0) begin
                report("result with nothing pending"); return;
            end
            e = pending_q.pop_front();
            if (u !== e.kind) report($sformatf("kind %0d, want %0d", u, e.kind));
            if (d[31:0] !== e.edge_v) report($sformatf("edge %h, want %h", d[31:0], e.edge_v));
            if (d[67:32] !== e.weight)
                report($sformatf("weight %h, want %h", d[67:32], e.weight));
            if (d[68] !== e.bad) report($sformatf("bad %b, want %b", d[68], e.bad));
        endtask

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [71:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    binner_board board = new();
    bit          hold_sink = 0;
    logic [31:0] pos;

    weighted_interval_union_binner_unit dut (.*);

    always #6 i_clk = ~i_clk;

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // valid stays high after acceptance; drop it on a gap or through bus_idle
    task automatic send_event(bit first, logic [31:0] val, logic [3:0] idx, bit start,
                              logic [31:0] far_v, logic [31:0] w, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= first;
        s_axis_tdata  <= {3'b0, w, far_v, start, idx, val};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_event(first, val, idx, start, far_v, w);
    endtask

    task automatic bus_idle();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending_q.size() != 0) @(posedge i_clk);
    endtask

    // random well-formed set with occasional noise
    task automatic random_set(bit gaps);
        int n;
        logic [3:0] idx;
        logic [31:0] step;
        pos = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000);
        send_event(1, pos, 4'($urandom), 1, pos + $urandom_range(0, 500), $urandom, gaps);
        n = $urandom_range(3, 12);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: step = 0;
                1: step = $urandom;
                default: step = $urandom_range(1, 300);
            endcase
            if (64'(pos) + step <= 64'hFFFF_FFFF) pos = pos + step;
            idx = 4'($urandom);
            case ($urandom_range(0, 9))
                0: send_event(0, pos - $urandom_range(1, 50), idx, 1, $urandom, $urandom, gaps);
                1, 2, 3, 4: send_event(0, pos, idx, 0, 0, 0, gaps);
                5: send_event(0, pos, idx, 1, $urandom, $urandom, gaps);
                default: send_event(0, pos, idx, 1,
                    $urandom_range(0, 7) == 0 ? pos - 1 : pos + $urandom_range(0, 1000),
                    $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom, gaps);
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_bin(m_axis_tdata, m_axis_tuser);
    end

    initial begin : sink
        int g;
        @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                m_axis_tready <= 0;
                repeat (400) @(posedge i_clk);
                hold_sink = 0;
            end
            g = $urandom_range(0, 2) == 0 ? gap_len() : 0;
            if (g > 0) begin
                m_axis_tready <= 0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        board.errors = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // no open set, then edges of the fields
        send_event(0, 5, 0, 1, 9, 1, 0);
        send_event(1, 0, 0, 0, 0, 0, 0);
        send_event(0, 0, 15, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_event(0, 0, 0, 1, 0, 32'h0001_0000, 0);
        send_event(0, 10, 3, 1, 5, 32'hFFFF_FFFF, 0);
        send_event(0, 9, 3, 1, 20, 5, 0);
        send_event(0, 100, 15, 1, 200, 32'h0002_0000, 0);
        send_event(0, 32'hFFFF_FFFF, 15, 0, 0, 0, 0);
        send_event(0, 32'hFFFF_FFFF, 15, 0, 0, 0, 0);
        send_event(1, 32'hFFFF_FFFE, 7, 0, 0, 0, 0);
        for (int s = 0; s < SOURCES; s++)
            send_event(0, 32'hFFFF_FFFE, 4'(s), 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_event(0, 32'hFFFF_FFFF, 2, 0, 0, 0, 0);
        bus_idle();
        drain();
        // long sink hold while the source keeps offering
        hold_sink = 1;
        repeat (6) random_set(0);
        bus_idle();
        drain();
        repeat (215) random_set($urandom_range(0, 3) != 0);
        bus_idle();
        drain();
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("weighted_interval_union_binner_unit_tb: done, clean");
        else
            $display("weighted_interval_union_binner_unit_tb: done, errors");
        $finish;
    end

    initial begin : watchdog
        #(12 * 12000000);
        $display("weighted_interval_union_binner_unit_tb: done, errors");
        $finish;
    end
endmodule
